[hdl/bbpo_pkg.sv]
// Shared types and constants for the brick/paddle/ball pixel overlay.
// No dependencies; used by brick_ball_paddle_pixel_overlay.
package bbpo_pkg;

   // Request operation codes
   typedef enum logic [1:0] {
      OP_PIXEL      = 2'd0,
      OP_RAM_WRITE  = 2'd1,
      OP_PORT_WRITE = 2'd2
   } op_type;

   // Number of brick rows drawn
   localparam int unsigned BRICK_ROWS = 14;

   // Work-RAM shadow offsets
   localparam logic [9:0] RAM_HIDE_ROW   = 10'h02b;
   localparam logic [9:0] RAM_HIDE_COL   = 10'h02c;
   localparam logic [9:0] RAM_MODE       = 10'h033;
   localparam logic [4:0] RAM_BRICK_PAGE = 5'b00010;   // addr[9:5] of 0x40..0x5f

   // Port numbers
   localparam logic [9:0] PORT_CONTROL = 10'd1;
   localparam logic [9:0] PORT_PADDLE  = 10'd5;
   localparam logic [9:0] PORT_BALL_X  = 10'd6;
   localparam logic [9:0] PORT_BALL_Y  = 10'd7;

   // Control port bits
   localparam int unsigned CTL_RED_BIT    = 6;
   localparam int unsigned CTL_SHORT_BIT  = 4;
   localparam int unsigned CTL_BOTTOM_BIT = 3;

   // Mode byte bank select bit
   localparam int unsigned MODE_BANK_BIT = 4;

   // Pens
   localparam logic [3:0] PEN_WHITE  = 4'hf;
   localparam logic [3:0] PEN_GREEN  = 4'h5;
   localparam logic [3:0] PEN_YELLOW = 4'h7;
   localparam logic [3:0] PEN_RED    = 4'h3;

   // Geometry
   localparam logic [7:0] BRICK_X_START = 8'd152;  // 160 - 8
   localparam logic [7:0] FIELD_Y_TOP   = 8'd16;
   localparam logic [7:0] PADDLE_X_LO   = 8'd38;
   localparam logic [7:0] PADDLE_X_HI   = 8'd41;
   localparam logic [9:0] BALL_X_OFFSET = 10'd10;  // ball spans ball_x-10 .. ball_x-8
   localparam logic [7:0] FRAME_X_END   = 8'd216;
   localparam logic [7:0] FRAME_R_HI    = 8'd221;
   localparam logic [7:0] FRAME_TOP_HI  = 8'd19;
   localparam logic [7:0] FRAME_BOT_LO  = 8'd238;
   localparam logic [7:0] FRAME_BOT_HI  = 8'd241;

endpackage

[hdl/brick_ball_paddle_pixel_overlay.sv]
// Top level of the brick/paddle/ball pixel overlay: shadow registers and
// the two-stage pixel pen pipeline. Depends on bbpo_pkg.
//
// channel  direction  ports                                       notes
// req      in         req_valid/req_ready, req_op, req_address,   pixel query or write
//                     req_data, req_pixel_x, req_pixel_y,
//                     req_background_pen
// rsp      out        rsp_valid/rsp_ready, rsp_pen                one per pixel query
//
// One request per clock sustained while the result is not stalled. A
// request waits in the input register, where a write updates the shadow
// state and a query computes its pen, registered into the result register.
// Synchronous active-high reset clears all shadow state and both valids.
// A stalled result stalls only a query in the input register, not a write.
module brick_ball_paddle_pixel_overlay #(
   parameter int unsigned BRICK_ROWS = bbpo_pkg::BRICK_ROWS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   input  logic [9:0] req_address,
   input  logic [7:0] req_data,
   input  logic [7:0] req_pixel_x,
   input  logic [7:0] req_pixel_y,
   input  logic [3:0] req_background_pen,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_pen
);

   // ---------------- input register ----------------
   logic               s1_valid_ff, s1_valid_in;
   bbpo_pkg::op_type   s1_op_ff;
   logic [9:0]         s1_address_ff;
   logic [7:0]         s1_data_ff;
   logic [7:0]         s1_x_ff;
   logic [7:0]         s1_y_ff;
   logic [3:0]         s1_bg_ff;

   // ---------------- result register ----------------
   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         rsp_pen_ff, rsp_pen_in;

   // ---------------- shadow state ----------------
   logic [7:0] brick_ff [32];
   logic [7:0] hide_row_ff;
   logic [7:0] hide_col_ff;
   logic [7:0] mode_ff;
   logic [7:0] paddle_ff;
   logic [7:0] ball_x_ff;
   logic [7:0] ball_y_ff;
   logic       red_bank_ff;
   logic       short_paddle_ff;
   logic       bottom_edge_ff;

   logic s1_is_query;
   logic s1_advance;
   logic req_accept;

   // A query leaves stage 1 only when the result register can take it;
   // writes and the unused op never produce a result.
   assign s1_is_query = (s1_op_ff == bbpo_pkg::OP_PIXEL);
   assign s1_advance  = s1_valid_ff && (!s1_is_query || !rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || s1_advance;
   assign req_accept  = req_valid && req_ready;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = (s1_advance && s1_is_query) || (rsp_valid_ff && !rsp_ready);

   // ---------------- pixel pen logic ----------------
   logic [7:0] bx, by;
   logic [2:0] brick_bit;
   logic [3:0] brick_row;
   logic [4:0] brick_idx;
   logic [7:0] brick_byte;
   logic       brick_hit, brick_blink, brick_draw;
   logic [8:0] pad_dy;
   logic       pad_hit;
   logic [9:0] ball_dx;
   logic [8:0] ball_dy;
   logic       ball_hit;
   logic       y_field;
   logic       frame_hit;
   logic [3:0] brick_pen;

   always_comb begin
      // bricks: 3x15 cells on a 4x16 pitch starting at (152,16)
      bx         = s1_x_ff - bbpo_pkg::BRICK_X_START;
      by         = s1_y_ff - bbpo_pkg::FIELD_Y_TOP;
      brick_bit  = bx[4:2];
      brick_row  = by[7:4];
      brick_idx  = {mode_ff[bbpo_pkg::MODE_BANK_BIT], brick_row};
      brick_byte = brick_ff[brick_idx];
      brick_hit  = (s1_x_ff >= bbpo_pkg::BRICK_X_START) && (bx[7:5] == 3'd0)
                   && (bx[1:0] != 2'd3)
                   && (s1_y_ff >= bbpo_pkg::FIELD_Y_TOP)
                   && ({1'b0, brick_row} < 5'(BRICK_ROWS))
                   && (by[3:0] != 4'hf);
      brick_blink = (mode_ff[1:0] == 2'b11) && (hide_col_ff == {5'd0, brick_bit})
                    && (hide_row_ff == {4'd0, brick_row});
      brick_draw  = brick_hit && brick_byte[brick_bit] && !brick_blink;
      if (red_bank_ff) begin
         brick_pen = bbpo_pkg::PEN_RED;
      end else if (brick_bit[2]) begin
         brick_pen = bbpo_pkg::PEN_YELLOW;
      end else begin
         brick_pen = bbpo_pkg::PEN_GREEN;
      end

      // paddle: no wrap, bottom part clipped at 255
      pad_dy  = {1'b0, s1_y_ff} - {1'b0, paddle_ff};
      pad_hit = !bottom_edge_ff
                && (s1_x_ff >= bbpo_pkg::PADDLE_X_LO) && (s1_x_ff <= bbpo_pkg::PADDLE_X_HI)
                && !pad_dy[8]
                && (pad_dy[7:0] < (short_paddle_ff ? 8'd8 : 8'd16));

      // ball: x offset by 10 to the left, 3x3
      ball_dx  = {2'd0, s1_x_ff} + bbpo_pkg::BALL_X_OFFSET - {2'd0, ball_x_ff};
      ball_dy  = {1'b0, s1_y_ff} - {1'b0, ball_y_ff};
      ball_hit = (ball_dx < 10'd3) && (ball_dy < 9'd3);

      // edge frame
      y_field   = (s1_y_ff >= bbpo_pkg::FIELD_Y_TOP) && (s1_y_ff <= bbpo_pkg::FRAME_BOT_HI);
      frame_hit = ((s1_x_ff < bbpo_pkg::FRAME_X_END) && (s1_y_ff >= bbpo_pkg::FIELD_Y_TOP)
                   && (s1_y_ff <= bbpo_pkg::FRAME_TOP_HI))
                  || ((s1_x_ff >= bbpo_pkg::FRAME_X_END) && (s1_x_ff <= bbpo_pkg::FRAME_R_HI)
                   && y_field)
                  || ((s1_x_ff < bbpo_pkg::FRAME_X_END) && (s1_y_ff >= bbpo_pkg::FRAME_BOT_LO)
                   && (s1_y_ff <= bbpo_pkg::FRAME_BOT_HI))
                  || (bottom_edge_ff && (s1_x_ff >= bbpo_pkg::PADDLE_X_LO)
                   && (s1_x_ff <= bbpo_pkg::PADDLE_X_HI) && y_field);

      // layer priority: frame over ball over paddle over bricks
      if (frame_hit || ball_hit || pad_hit) begin
         rsp_pen_in = bbpo_pkg::PEN_WHITE;
      end else if (brick_draw) begin
         rsp_pen_in = brick_pen;
      end else begin
         rsp_pen_in = s1_bg_ff;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         hide_row_ff     <= '0;
         hide_col_ff     <= '0;
         mode_ff         <= '0;
         paddle_ff       <= '0;
         ball_x_ff       <= '0;
         ball_y_ff       <= '0;
         red_bank_ff     <= 1'b0;
         short_paddle_ff <= 1'b0;
         bottom_edge_ff  <= 1'b0;
         for (int i = 0; i < 32; i++) begin
            brick_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_advance) begin
            case (s1_op_ff)
               bbpo_pkg::OP_RAM_WRITE: begin
                  if (s1_address_ff[9:5] == bbpo_pkg::RAM_BRICK_PAGE) begin
                     brick_ff[s1_address_ff[4:0]] <= s1_data_ff;
                  end else if (s1_address_ff == bbpo_pkg::RAM_HIDE_ROW) begin
                     hide_row_ff <= s1_data_ff;
                  end else if (s1_address_ff == bbpo_pkg::RAM_HIDE_COL) begin
                     hide_col_ff <= s1_data_ff;
                  end else if (s1_address_ff == bbpo_pkg::RAM_MODE) begin
                     mode_ff <= s1_data_ff;
                  end
               end
               bbpo_pkg::OP_PORT_WRITE: begin
                  if (s1_address_ff == bbpo_pkg::PORT_CONTROL) begin
                     red_bank_ff     <= s1_data_ff[bbpo_pkg::CTL_RED_BIT];
                     short_paddle_ff <= s1_data_ff[bbpo_pkg::CTL_SHORT_BIT];
                     bottom_edge_ff  <= s1_data_ff[bbpo_pkg::CTL_BOTTOM_BIT];
                  end else if (s1_address_ff == bbpo_pkg::PORT_PADDLE) begin
                     paddle_ff <= s1_data_ff;
                  end else if (s1_address_ff == bbpo_pkg::PORT_BALL_X) begin
                     ball_x_ff <= s1_data_ff;
                  end else if (s1_address_ff == bbpo_pkg::PORT_BALL_Y) begin
                     ball_y_ff <= s1_data_ff;
                  end
               end
               default: begin
                  // query, or unused op: no state change
               end
            endcase
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff      <= bbpo_pkg::op_type'(req_op);
         s1_address_ff <= req_address;
         s1_data_ff    <= req_data;
         s1_x_ff       <= req_pixel_x;
         s1_y_ff       <= req_pixel_y;
         s1_bg_ff      <= req_background_pen;
      end
      if (s1_advance && s1_is_query) begin
         rsp_pen_ff <= rsp_pen_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pen   = rsp_pen_ff;

   // ---------------- assertions ----------------
   // A result only ever comes from a query leaving stage 1.
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_is_query))
      else $error("result raised without a pixel query");

   // Input is back-pressured only when a query is stuck behind a full output.
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s1_is_query && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without a blocked query");

   // A mode byte write lands in the shadow register.
   a_mode_write: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_op_ff == bbpo_pkg::OP_RAM_WRITE && s1_address_ff == bbpo_pkg::RAM_MODE)
      |=> (mode_ff == $past(s1_data_ff)))
      else $error("mode byte write lost");

endmodule
